// File: hdl/flvmp3_pkg.sv
`timescale 1ns / 1ps

package flvmp3_pkg;

    // field widths
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 4;
    localparam int LEN_W    = 24;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PAYLOAD    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FLV    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_AUDIO   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_OFFSET = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MALFORMED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_MP3    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NONE       = 3'd7;

    // stream constants
    localparam logic [DATA_W-1:0] AUDIO_TYPE   = 8'h08;
    localparam logic [DATA_W-1:0] CODEC_MASK   = 8'hf0;
    localparam logic [DATA_W-1:0] CODEC_MP3    = 8'h20;
    localparam logic [DATA_W-1:0] AUDIO_FLAG   = 8'h04;
    localparam logic [DATA_W-1:0] FILE_HDR_LEN = 8'd9;

    // header byte positions
    localparam logic [IDX_W-1:0] IDX_FLAGS     = 4'd4;
    localparam logic [IDX_W-1:0] IDX_OFS_FIRST = 4'd5;
    localparam logic [IDX_W-1:0] IDX_OFS_LAST  = 4'd8;
    localparam logic [IDX_W-1:0] IDX_SIG_END   = 4'd3;
    localparam logic [IDX_W-1:0] IDX_TYPE      = 4'd4;
    localparam logic [IDX_W-1:0] IDX_LEN_FIRST = 4'd5;
    localparam logic [IDX_W-1:0] IDX_LEN_LAST  = 4'd7;
    localparam logic [IDX_W-1:0] IDX_TRAILER   = 4'd3;
    localparam logic [IDX_W-1:0] IDX_TAG_LAST  = 4'd14;

    // signature bytes "FLV"
    function automatic logic [DATA_W-1:0] sig_byte(input logic [1:0] pos);
        logic [DATA_W-1:0] b;
        case (pos)
            2'd0:    b = 8'h46;
            2'd1:    b = 8'h4c;
            2'd2:    b = 8'h56;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: hdl/flv_audio_mp3_extractor_top.sv
`timescale 1ns / 1ps

// channel  direction  signals                              transaction when
// input    in         i_valid, o_stall, i_data_byte,       i_valid && !o_stall
//                     i_final_byte
// output   out        o_valid, i_stall, o_payload_byte,    o_valid && !i_stall
//                     o_status
//
// one byte per cycle while the output is not stalled; a byte is parsed from the
// input register once it is taken, and its result is registered in the result
// register, which drives o_valid.
// the parse state (phase, index, body count) updates once per byte in one pass.
// i_rst_n is synchronous, active low; it returns the parser to the file header.
// a stall on the output holds the result register and, once the input register
// is also full, raises o_stall.

module flv_audio_mp3_extractor_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [flvmp3_pkg::DATA_W-1:0]      i_data_byte,
    input  logic                               i_final_byte,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [flvmp3_pkg::DATA_W-1:0]      o_payload_byte,
    output logic [flvmp3_pkg::STATUS_W-1:0]    o_status
);
    import flvmp3_pkg::*;

    typedef enum logic [1:0] {
        PH_FILE_HDR = 2'd0,
        PH_TAG_HDR  = 2'd1,
        PH_BODY     = 2'd2,
        PH_SWALLOW  = 2'd3
    } t_phase;

    // input register
    logic              r_in_valid;
    logic [DATA_W-1:0] r_in_data;
    logic              r_in_final;

    // parse state
    t_phase            r_phase, n_phase;
    logic [IDX_W-1:0]  r_byte_index, n_byte_index;
    logic [LEN_W-1:0]  r_body_left, n_body_left;
    logic              r_audio_tag, n_audio_tag;
    logic [LEN_W-1:0]  r_length_acc, n_length_acc;

    // result register
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_payload;
    logic [STATUS_W-1:0] r_out_status;

    logic                w_adv;
    logic [STATUS_W-1:0] w_st;
    logic [DATA_W-1:0]   w_pay;

    // handshake
    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !w_adv;
    assign o_valid = r_out_valid;
    assign o_payload_byte = r_out_payload;
    assign o_status = r_out_status;

    // one byte of parsing
    always_comb begin
        n_phase      = r_phase;
        n_byte_index = r_byte_index;
        n_body_left  = r_body_left;
        n_audio_tag  = r_audio_tag;
        n_length_acc = r_length_acc;
        w_st         = ST_NONE;
        w_pay        = '0;
        case (r_phase)
            PH_FILE_HDR: begin
                if (r_byte_index < IDX_SIG_END) begin
                    if (r_in_data != sig_byte(r_byte_index[1:0])) w_st = ST_NOT_FLV;
                end else if (r_byte_index == IDX_FLAGS) begin
                    if ((r_in_data & AUDIO_FLAG) == '0) w_st = ST_NO_AUDIO;
                end else if (r_byte_index >= IDX_OFS_FIRST && r_byte_index < IDX_OFS_LAST) begin
                    if (r_in_data != '0) w_st = ST_BAD_OFFSET;
                end else if (r_byte_index == IDX_OFS_LAST) begin
                    if (r_in_data != FILE_HDR_LEN) w_st = ST_BAD_OFFSET;
                end
                if (w_st == ST_NONE) begin
                    if (r_in_final) begin
                        w_st = (r_byte_index == IDX_OFS_LAST) ? ST_MALFORMED : ST_NOT_FLV;
                    end else if (r_byte_index >= IDX_OFS_LAST) begin
                        n_phase      = PH_TAG_HDR;
                        n_byte_index = '0;
                    end else begin
                        n_byte_index = r_byte_index + 1'b1;
                    end
                end
            end
            PH_TAG_HDR: begin
                if (r_in_final) begin
                    w_st = (r_byte_index == IDX_TRAILER) ? ST_DONE : ST_MALFORMED;
                end else begin
                    if (r_byte_index == IDX_TYPE) begin
                        n_audio_tag = (r_in_data == AUDIO_TYPE);
                    end else if (r_byte_index >= IDX_LEN_FIRST &&
                                 r_byte_index <= IDX_LEN_LAST) begin
                        n_length_acc = {r_length_acc[LEN_W-DATA_W-1:0], r_in_data};
                    end
                    if (r_byte_index >= IDX_TAG_LAST) begin
                        n_body_left  = n_length_acc;
                        n_byte_index = '0;
                        if (n_length_acc == '0) begin
                            // empty audio body has no codec byte
                            if (n_audio_tag) w_st = ST_MALFORMED;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end else begin
                        n_byte_index = r_byte_index + 1'b1;
                    end
                end
            end
            PH_BODY: begin
                if (r_audio_tag) begin
                    if (r_byte_index == '0) begin
                        if ((r_in_data & CODEC_MASK) != CODEC_MP3) w_st = ST_NOT_MP3;
                        n_byte_index = {{(IDX_W-1){1'b0}}, 1'b1};
                    end else begin
                        w_st  = ST_PAYLOAD;
                        w_pay = r_in_data;
                    end
                end
                if (w_st != ST_NOT_MP3 && r_in_final) begin
                    w_st  = ST_MALFORMED;
                    w_pay = '0;
                end else begin
                    n_body_left = r_body_left - 1'b1;
                    if (r_body_left == {{(LEN_W-1){1'b0}}, 1'b1}) begin
                        n_phase      = PH_TAG_HDR;
                        n_byte_index = '0;
                    end
                end
            end
            default: begin
                w_st = ST_NONE;
            end
        endcase
        // end of file restarts; an error swallows the rest
        if (r_in_final) begin
            n_phase      = PH_FILE_HDR;
            n_byte_index = '0;
            n_body_left  = '0;
            n_audio_tag  = 1'b0;
            n_length_acc = '0;
        end else if (w_st != ST_NONE && w_st != ST_PAYLOAD) begin
            n_phase = PH_SWALLOW;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
        if (i_valid && !o_stall) begin
            r_in_data  <= i_data_byte;
            r_in_final <= i_final_byte;
        end
    end

    // parse state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FILE_HDR;
            r_byte_index <= '0;
            r_body_left  <= '0;
            r_audio_tag  <= 1'b0;
            r_length_acc <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_adv) begin
                r_phase      <= n_phase;
                r_byte_index <= n_byte_index;
                r_body_left  <= n_body_left;
                r_audio_tag  <= n_audio_tag;
                r_length_acc <= n_length_acc;
                r_out_valid  <= (w_st != ST_NONE);
            end else if (!i_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
        if (w_adv && w_st != ST_NONE) begin
            r_out_payload <= w_pay;
            r_out_status  <= w_st;
        end
    end

    // checks
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != ST_NONE)
        else $error("result carries no status code");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_PAYLOAD) |-> o_payload_byte == '0)
        else $error("status result with nonzero payload");

    a_final_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_final) |=> (r_phase == PH_FILE_HDR && r_byte_index == '0))
        else $error("final byte did not restart the parser");

    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_body_left != '0)
        else $error("body phase with no bytes left");

endmodule
